[rtl/cfa_pkg.sv]
package cfa_pkg;

  localparam int unsigned EXP_BITS  = 8;
  localparam int unsigned FRAC_BITS = 23;
  localparam int unsigned HAS_SIGN  = 1;

  typedef struct packed {
    logic valid;
    logic sub;
    logic sgn;
    logic alt_sgn;
    logic zero;
    logic unf;
  } cfa_ctl_t;

endpackage

[rtl/custom_float_adder_core.sv]
// Pipelined adder for packed floats: [sign][exponent][fraction].
// Request: raise start with addend_a_i/addend_b_i; it is taken at any
// clock edge where start is high and busy is low. busy is always low,
// so a new request may be issued every cycle.
// Result: sum_bits_o with overflow_flag_o/underflow_flag_o, valid for
// one cycle while done_o is high.
// Throughput: one request per cycle; the result passes through six register
// stages (swap, align shift, add/subtract, leading-zero count,
// normalize shift, round/pack).
// The receiver cannot stall; results must be taken when done_o is high.
// Reset (rst_ni low, async) clears all valid bits; requests in flight
// are dropped and no done_o is produced for them.
module custom_float_adder_core #(
  parameter int unsigned EXP_BITS  = cfa_pkg::EXP_BITS,
  parameter int unsigned FRAC_BITS = cfa_pkg::FRAC_BITS,
  parameter int unsigned HAS_SIGN  = cfa_pkg::HAS_SIGN
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] addend_a_i,
  input  logic [31:0] addend_b_i,
  output logic        done_o,
  output logic [31:0] sum_bits_o,
  output logic        overflow_flag_o,
  output logic        underflow_flag_o
);

  localparam int unsigned MW = FRAC_BITS + 3;
  localparam int unsigned EW = EXP_BITS + 1;

  cfa_pkg::cfa_ctl_t ctl_b, ctl_c, ctl_e;
  logic [EW-1:0]     e_b, e_c, e_e;
  logic [MW-1:0]     m1_b, m2_b, mag_c, mag_e;

  assign busy = 1'b0;

  cfa_align #(
    .EXP_BITS(EXP_BITS), .FRAC_BITS(FRAC_BITS), .HAS_SIGN(HAS_SIGN)
  ) u_align (
    .clk_i, .rst_ni,
    .valid_i(start & ~busy),
    .a_i(addend_a_i), .b_i(addend_b_i),
    .ctl_o(ctl_b), .e_o(e_b), .m1_o(m1_b), .m2_o(m2_b)
  );

  cfa_addsub #(
    .EXP_BITS(EXP_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_addsub (
    .clk_i, .rst_ni,
    .ctl_i(ctl_b), .e_i(e_b), .m1_i(m1_b), .m2_i(m2_b),
    .ctl_o(ctl_c), .e_o(e_c), .mag_o(mag_c)
  );

  cfa_norm #(
    .EXP_BITS(EXP_BITS), .FRAC_BITS(FRAC_BITS)
  ) u_norm (
    .clk_i, .rst_ni,
    .ctl_i(ctl_c), .e_i(e_c), .mag_i(mag_c),
    .ctl_o(ctl_e), .e_o(e_e), .mag_o(mag_e)
  );

  cfa_round #(
    .EXP_BITS(EXP_BITS), .FRAC_BITS(FRAC_BITS), .HAS_SIGN(HAS_SIGN)
  ) u_round (
    .clk_i, .rst_ni,
    .ctl_i(ctl_e), .e_i(e_e), .mag_i(mag_e),
    .done_o, .sum_bits_o, .overflow_flag_o, .underflow_flag_o
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 6))
    else $error("result without request six cycles earlier");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(overflow_flag_o && underflow_flag_o))
    else $error("overflow and underflow together");

  a_zero_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_e.valid && ctl_e.zero |=> !overflow_flag_o && !underflow_flag_o)
    else $error("flag set on exact cancellation");

  a_sub_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_c.valid && ctl_c.zero |-> ctl_c.sub)
    else $error("zero marked on add path");
`endif

endmodule

[rtl/cfa_align.sv]
module cfa_align #(
  parameter int unsigned EXP_BITS  = cfa_pkg::EXP_BITS,
  parameter int unsigned FRAC_BITS = cfa_pkg::FRAC_BITS,
  parameter int unsigned HAS_SIGN  = cfa_pkg::HAS_SIGN,
  localparam int unsigned MW = FRAC_BITS + 3,
  localparam int unsigned EW = EXP_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output cfa_pkg::cfa_ctl_t ctl_o,
  output logic [EW-1:0]     e_o,
  output logic [MW-1:0]     m1_o,
  output logic [MW-1:0]     m2_o
);

  localparam int unsigned FW = HAS_SIGN + EXP_BITS + FRAC_BITS;
  localparam int unsigned PW = (FW > 32) ? FW : 33;

  logic [PW-1:0]       pa, pb;
  logic [EXP_BITS-1:0] ea, eb;
  logic                sa, sb, swap;
  logic [MW-1:0]       ma, mb;

  logic                va_q;
  logic [EXP_BITS-1:0] e1a_q, gapa_q;
  logic [MW-1:0]       m1a_q, m2a_q;
  logic                s1a_q, s2a_q;

  cfa_pkg::cfa_ctl_t   ctl_d, ctl_q;
  logic [MW-1:0]       m2_d;
  logic [EW-1:0]       e_q;
  logic [MW-1:0]       m1_q, m2_q;

  assign pa   = PW'(a_i);
  assign pb   = PW'(b_i);
  assign ea   = pa[FRAC_BITS +: EXP_BITS];
  assign eb   = pb[FRAC_BITS +: EXP_BITS];
  assign sa   = (HAS_SIGN != 0) ? pa[FRAC_BITS+EXP_BITS] : 1'b0;
  assign sb   = (HAS_SIGN != 0) ? pb[FRAC_BITS+EXP_BITS] : 1'b0;
  assign ma   = {1'b0, (ea != '0), pa[FRAC_BITS-1:0], 1'b0};
  assign mb   = {1'b0, (eb != '0), pb[FRAC_BITS-1:0], 1'b0};
  assign swap = ea < eb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    e1a_q  <= swap ? eb : ea;
    gapa_q <= swap ? (eb - ea) : (ea - eb);
    m1a_q  <= swap ? mb : ma;
    m2a_q  <= swap ? ma : mb;
    s1a_q  <= swap ? sb : sa;
    s2a_q  <= swap ? sa : sb;
  end

  always_comb begin
    ctl_d         = '0;
    ctl_d.valid   = va_q;
    ctl_d.sub     = s1a_q ^ s2a_q;
    ctl_d.sgn     = s1a_q;
    ctl_d.alt_sgn = s2a_q;
    m2_d          = m2a_q >> gapa_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q  <= EW'(e1a_q);
    m1_q <= m1a_q;
    m2_q <= m2_d;
  end

  assign ctl_o = ctl_q;
  assign e_o   = e_q;
  assign m1_o  = m1_q;
  assign m2_o  = m2_q;

endmodule

[rtl/cfa_addsub.sv]
module cfa_addsub #(
  parameter int unsigned EXP_BITS  = cfa_pkg::EXP_BITS,
  parameter int unsigned FRAC_BITS = cfa_pkg::FRAC_BITS,
  localparam int unsigned MW = FRAC_BITS + 3,
  localparam int unsigned EW = EXP_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfa_pkg::cfa_ctl_t ctl_i,
  input  logic [EW-1:0]     e_i,
  input  logic [MW-1:0]     m1_i,
  input  logic [MW-1:0]     m2_i,
  output cfa_pkg::cfa_ctl_t ctl_o,
  output logic [EW-1:0]     e_o,
  output logic [MW-1:0]     mag_o
);

  cfa_pkg::cfa_ctl_t ctl_d, ctl_q;
  logic [EW-1:0]     e_d, e_q;
  logic [MW-1:0]     mag_d, mag_q, sum, d12, d21;
  logic              lt;

  assign sum = m1_i + m2_i;
  assign d12 = m1_i - m2_i;
  assign d21 = m2_i - m1_i;
  assign lt  = m1_i < m2_i;

  always_comb begin
    ctl_d = ctl_i;
    e_d   = e_i;
    mag_d = sum;
    if (!ctl_i.sub) begin
      if (sum[MW-1]) begin
        mag_d = sum >> 1;
        e_d   = e_i + EW'(1);
      end
    end else begin
      mag_d      = lt ? d21 : d12;
      ctl_d.sgn  = lt ? ctl_i.alt_sgn : ctl_i.sgn;
      ctl_d.zero = (mag_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q   <= e_d;
    mag_q <= mag_d;
  end

  assign ctl_o = ctl_q;
  assign e_o   = e_q;
  assign mag_o = mag_q;

endmodule

[rtl/cfa_norm.sv]
module cfa_norm #(
  parameter int unsigned EXP_BITS  = cfa_pkg::EXP_BITS,
  parameter int unsigned FRAC_BITS = cfa_pkg::FRAC_BITS,
  localparam int unsigned MW = FRAC_BITS + 3,
  localparam int unsigned EW = EXP_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfa_pkg::cfa_ctl_t ctl_i,
  input  logic [EW-1:0]     e_i,
  input  logic [MW-1:0]     mag_i,
  output cfa_pkg::cfa_ctl_t ctl_o,
  output logic [EW-1:0]     e_o,
  output logic [MW-1:0]     mag_o
);

  localparam int unsigned LW = $clog2(FRAC_BITS + 3);
  localparam int unsigned CW = (LW > EW) ? LW : EW;

  logic [LW-1:0]     lz_d, lz_q;
  cfa_pkg::cfa_ctl_t c4_q, ctl_d, ctl_q;
  logic [EW-1:0]     e4_q, e_d, e_q;
  logic [MW-1:0]     m4_q, mag_d, mag_q;
  logic [CW-1:0]     sh;

  // leading zeros counted from the hidden position down
  always_comb begin
    lz_d = LW'(FRAC_BITS + 2);
    for (int i = 0; i < FRAC_BITS + 2; i++) begin
      if (mag_i[i]) lz_d = LW'(FRAC_BITS + 1 - i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q  <= '0;
      ctl_q <= '0;
    end else begin
      c4_q  <= ctl_i;
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lz_q  <= lz_d;
    e4_q  <= e_i;
    m4_q  <= mag_i;
    e_q   <= e_d;
    mag_q <= mag_d;
  end

  always_comb begin
    sh = '0;
    if (c4_q.sub) begin
      sh = (CW'(lz_q) < CW'(e4_q)) ? CW'(lz_q) : CW'(e4_q);
    end
    mag_d     = m4_q << sh;
    e_d       = EW'(CW'(e4_q) - sh);
    ctl_d     = c4_q;
    ctl_d.unf = c4_q.sub & ~mag_d[FRAC_BITS+1];
  end

  assign ctl_o = ctl_q;
  assign e_o   = e_q;
  assign mag_o = mag_q;

endmodule

[rtl/cfa_round.sv]
module cfa_round #(
  parameter int unsigned EXP_BITS  = cfa_pkg::EXP_BITS,
  parameter int unsigned FRAC_BITS = cfa_pkg::FRAC_BITS,
  parameter int unsigned HAS_SIGN  = cfa_pkg::HAS_SIGN,
  localparam int unsigned MW = FRAC_BITS + 3,
  localparam int unsigned EW = EXP_BITS + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfa_pkg::cfa_ctl_t ctl_i,
  input  logic [EW-1:0]     e_i,
  input  logic [MW-1:0]     mag_i,
  output logic              done_o,
  output logic [31:0]       sum_bits_o,
  output logic              overflow_flag_o,
  output logic              underflow_flag_o
);

  localparam int unsigned FW = HAS_SIGN + EXP_BITS + FRAC_BITS;
  localparam int unsigned PW = (FW > 32) ? FW : 33;
  localparam logic [EW-1:0] EXP_MAX = EW'((1 << EXP_BITS) - 1);

  logic [FRAC_BITS:0] fr;
  logic [EW-1:0]      er;
  logic               ovf_d, unf_d, sgn;
  logic [PW-1:0]      res;
  logic               done_q;
  logic [31:0]        sum_q;
  logic               ovf_q, unf_q;

  always_comb begin
    fr    = {1'b0, mag_i[FRAC_BITS:1]} + (FRAC_BITS+1)'(mag_i[0]);
    er    = e_i;
    ovf_d = 1'b0;
    unf_d = ctl_i.unf;
    sgn   = (HAS_SIGN != 0) ? ctl_i.sgn : 1'b0;
    if (fr[FRAC_BITS]) begin
      fr = '0;
      er = e_i + EW'(1);
    end
    if (er > EXP_MAX) begin
      er    = EXP_MAX;
      fr    = '0;
      ovf_d = 1'b1;
    end
    res = PW'(fr[FRAC_BITS-1:0]) | (PW'(er[EXP_BITS-1:0]) << FRAC_BITS)
        | (PW'(sgn) << (FRAC_BITS + EXP_BITS));
    if (ctl_i.zero) begin
      res   = '0;
      ovf_d = 1'b0;
      unf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= res[31:0];
    ovf_q <= ovf_d;
    unf_q <= unf_d;
  end

  assign done_o           = done_q;
  assign sum_bits_o       = sum_q;
  assign overflow_flag_o  = ovf_q;
  assign underflow_flag_o = unf_q;

endmodule
